// File: rtl/tcrd_pkg.sv
// Shared types, constants and register codes for the touch calibration and dwell block.
`timescale 1ns / 1ps
package tcrd_pkg;

  // Field widths
  localparam int unsigned RawW     = 16;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned OffsetW  = 25;
  localparam int unsigned GainW    = 11;
  localparam int unsigned TargetW  = 16;
  localparam int unsigned BoxW     = 64;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 64;

  // Q14 arithmetic: signed gain times zero-extended raw reading, then a wide accumulator
  localparam int unsigned FracW = 14;
  localparam int unsigned ProdW = GainW + RawW + 1;
  localparam int unsigned AccW  = ProdW + 2;

  // Defaults for top-level parameters
  localparam int unsigned ScreenXSizeDef = 320;
  localparam int unsigned ScreenYSizeDef = 240;
  localparam int unsigned MidDepthDef    = 2;
  localparam int unsigned OutDepthDef    = 2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_X_OFFSET      = 8'd0,
    CFG_X_GAIN_FROM_X = 8'd1,
    CFG_X_GAIN_FROM_Y = 8'd2,
    CFG_Y_OFFSET      = 8'd3,
    CFG_Y_GAIN_FROM_X = 8'd4,
    CFG_Y_GAIN_FROM_Y = 8'd5,
    CFG_DWELL_TARGET  = 8'd6,
    CFG_REGION_BOX    = 8'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DWELL_COUNTING = 2'd0,
    DWELL_DONE     = 2'd1,
    DWELL_ABORTED  = 2'd2
  } dwell_status_e;

  // Affine terms of one output axis
  typedef struct packed {
    logic signed [OffsetW-1:0] offset;
    logic signed [GainW-1:0]   gain_x;
    logic signed [GainW-1:0]   gain_y;
  } axis_cfg_t;

  // Region box, laid out so the 64-bit register maps directly (left lowest)
  typedef struct packed {
    logic [CoordW-1:0] height;
    logic [CoordW-1:0] width;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] left;
  } region_t;

  typedef struct packed {
    logic [TargetW-1:0] target;
    region_t            box;
  } dwell_cfg_t;

  // Calibrated sample passed from front to back
  typedef struct packed {
    logic              touched;
    logic [CoordW-1:0] cal_x;
    logic [CoordW-1:0] cal_y;
  } cal_item_t;

  // Finished result
  typedef struct packed {
    cal_item_t     cal;
    dwell_status_e status;
  } result_t;

endpackage

// File: rtl/tcrd_fifo.sv
// Small synchronous queue with push/full and pop/empty sides.
`timescale 1ns / 1ps
module tcrd_fifo import tcrd_pkg::*; #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store entry on a push transfer
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("fifo count exceeds depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("fifo count did not grow on push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wptr_q == rptr_q))
    else $error("fifo pointers differ while empty");

endmodule

// File: rtl/tcrd_front.sv
// Front end: two-stage Q14 affine calibration and clamp of each touch sample.
`timescale 1ns / 1ps
module tcrd_front import tcrd_pkg::*; #(
  parameter int unsigned SCREEN_X_SIZE = ScreenXSizeDef,
  parameter int unsigned SCREEN_Y_SIZE = ScreenYSizeDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            pen_down_i,
  input  logic [RawW-1:0] raw_x_i,
  input  logic [RawW-1:0] raw_y_i,
  input  axis_cfg_t       x_cfg_i,
  input  axis_cfg_t       y_cfg_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cal_item_t       out_item_o
);

  localparam int unsigned QW = AccW - 1 - FracW;
  localparam logic [CoordW-1:0] XLimit = CoordW'(SCREEN_X_SIZE);
  localparam logic [CoordW-1:0] YLimit = CoordW'(SCREEN_Y_SIZE);

  // Truncating divide by 16384 and clamp to 0..limit; negative sums clamp to zero
  function automatic logic [CoordW-1:0] clamp_q14(input logic signed [AccW-1:0] acc,
                                                  input logic [CoordW-1:0] limit);
    logic [QW-1:0]     q;
    logic [CoordW-1:0] qz;
    q  = acc[AccW-2:FracW];
    qz = CoordW'(q);
    if (acc[AccW-1]) begin
      return '0;
    end else if (qz > limit) begin
      return limit;
    end
    return qz;
  endfunction

  logic                    v1_q, v1_d, v2_q, v2_d;
  logic                    s1_ready, s2_ready;
  logic                    pen1_q;
  logic signed [ProdW-1:0] xx_q, xy_q, yx_q, yy_q;
  logic signed [AccW-1:0]  acc_x, acc_y;
  cal_item_t               item2_q, item2_d;

  assign s2_ready   = !v2_q || out_ready_i;
  assign s1_ready   = !v1_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign out_valid_o = v2_q;
  assign out_item_o  = item2_q;

  // Advance stage valids
  always_comb begin
    v1_d = s1_ready ? in_valid_i : v1_q;
    v2_d = s2_ready ? v1_q : v2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  // Stage 1: gain products
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      pen1_q <= pen_down_i;
      xx_q   <= x_cfg_i.gain_x * $signed({1'b0, raw_x_i});
      xy_q   <= x_cfg_i.gain_y * $signed({1'b0, raw_y_i});
      yx_q   <= y_cfg_i.gain_x * $signed({1'b0, raw_x_i});
      yy_q   <= y_cfg_i.gain_y * $signed({1'b0, raw_y_i});
    end
  end

  // Stage 2: sum with offset, scale, clamp; zero coordinates when the pen is up
  always_comb begin
    acc_x = AccW'(x_cfg_i.offset) + AccW'(xx_q) + AccW'(xy_q);
    acc_y = AccW'(y_cfg_i.offset) + AccW'(yx_q) + AccW'(yy_q);
    item2_d.touched = pen1_q;
    item2_d.cal_x   = pen1_q ? clamp_q14(acc_x, XLimit) : '0;
    item2_d.cal_y   = pen1_q ? clamp_q14(acc_y, YLimit) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && v1_q) begin
      item2_q <= item2_d;
    end
  end

endmodule

// File: rtl/tcrd_back.sv
// Back end: region test and dwell counting on calibrated samples.
`timescale 1ns / 1ps
module tcrd_back import tcrd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cal_item_t  in_item_i,
  input  dwell_cfg_t dwell_cfg_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    out_item_o
);

  logic [TargetW-1:0] hit_count_q, hit_count_d, hit_inc;
  logic [CoordW:0]    x_end, y_end;
  logic               x_in, y_in, xfer;
  dwell_status_e      status;

  assign xfer        = in_valid_i && out_ready_i;
  assign in_ready_o  = out_ready_i;
  assign out_valid_o = in_valid_i;

  // Region bounds without wrap
  assign x_end = {1'b0, dwell_cfg_i.box.left} + {1'b0, dwell_cfg_i.box.width};
  assign y_end = {1'b0, dwell_cfg_i.box.top} + {1'b0, dwell_cfg_i.box.height};
  assign x_in  = (in_item_i.cal_x >= dwell_cfg_i.box.left) && ({1'b0, in_item_i.cal_x} < x_end);
  assign y_in  = (in_item_i.cal_y >= dwell_cfg_i.box.top) && ({1'b0, in_item_i.cal_y} < y_end);
  assign hit_inc = hit_count_q + TargetW'(1);

  // Classify sample and update the dwell count
  always_comb begin
    hit_count_d = hit_count_q;
    status      = DWELL_ABORTED;
    if (!in_item_i.touched || !y_in) begin
      hit_count_d = '0;
    end else begin
      status = DWELL_COUNTING;
      if (x_in) begin
        if (hit_inc >= dwell_cfg_i.target) begin
          status      = DWELL_DONE;
          hit_count_d = '0;
        end else begin
          hit_count_d = hit_inc;
        end
      end
    end
    out_item_o.cal    = in_item_i;
    out_item_o.status = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_count_q <= '0;
    end else if (xfer) begin
      hit_count_q <= hit_count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && (status == DWELL_DONE || status == DWELL_ABORTED)) |=> (hit_count_q == '0))
    else $error("dwell count not cleared after done or abort");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !xfer |=> $stable(hit_count_q))
    else $error("dwell count moved without a transfer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && status == DWELL_DONE) |-> in_item_i.touched)
    else $error("done reported with pen up");

endmodule

// File: rtl/touch_calibrate_region_dwell_top.sv
// Top level: configuration registers, calibration front, queues and dwell back end.
// Path: a sample is registered in front stage one, then front stage two, then the middle
// queue and then the result queue, where its result becomes visible.
// Throughput: one sample per cycle unless a full queue stalls the front or dwell step.
// Reset (rst_ni low, asynchronous): queues empty, dwell count zero, registers zero
// except the dwell target, which resets to one.
`timescale 1ns / 1ps
module touch_calibrate_region_dwell_top import tcrd_pkg::*; #(
  parameter int unsigned SCREEN_X_SIZE = ScreenXSizeDef,
  parameter int unsigned SCREEN_Y_SIZE = ScreenYSizeDef,
  parameter int unsigned MidDepth      = MidDepthDef,
  parameter int unsigned OutDepth      = OutDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  logic                pen_down_i,
  input  logic [RawW-1:0]     raw_x_i,
  input  logic [RawW-1:0]     raw_y_i,
  output logic                empty,
  input  logic                pop,
  output logic                touched_o,
  output logic [CoordW-1:0]   cal_x_o,
  output logic [CoordW-1:0]   cal_y_o,
  output logic [1:0]          dwell_status_o
);

  localparam int unsigned CalW = $bits(cal_item_t);
  localparam int unsigned ResW = $bits(result_t);

  axis_cfg_t  x_cfg_q, y_cfg_q;
  dwell_cfg_t dwell_cfg_q;

  logic      front_ready, front_valid;
  cal_item_t front_item, mid_item;
  logic      mid_full, mid_empty, back_ready, back_valid, out_full;
  result_t   back_item, out_item;

  // Configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_cfg_q            <= '0;
      y_cfg_q            <= '0;
      dwell_cfg_q.target <= TargetW'(1);
      dwell_cfg_q.box    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_X_OFFSET:      x_cfg_q.offset     <= cfg_wdata_i[OffsetW-1:0];
        CFG_X_GAIN_FROM_X: x_cfg_q.gain_x     <= cfg_wdata_i[GainW-1:0];
        CFG_X_GAIN_FROM_Y: x_cfg_q.gain_y     <= cfg_wdata_i[GainW-1:0];
        CFG_Y_OFFSET:      y_cfg_q.offset     <= cfg_wdata_i[OffsetW-1:0];
        CFG_Y_GAIN_FROM_X: y_cfg_q.gain_x     <= cfg_wdata_i[GainW-1:0];
        CFG_Y_GAIN_FROM_Y: y_cfg_q.gain_y     <= cfg_wdata_i[GainW-1:0];
        CFG_DWELL_TARGET:  dwell_cfg_q.target <= cfg_wdata_i[TargetW-1:0];
        CFG_REGION_BOX:    dwell_cfg_q.box    <= region_t'(cfg_wdata_i[BoxW-1:0]);
        default: ;
      endcase
    end
  end

  assign full = !front_ready;

  tcrd_front #(
    .SCREEN_X_SIZE(SCREEN_X_SIZE),
    .SCREEN_Y_SIZE(SCREEN_Y_SIZE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (push),
    .in_ready_o (front_ready),
    .pen_down_i (pen_down_i),
    .raw_x_i    (raw_x_i),
    .raw_y_i    (raw_y_i),
    .x_cfg_i    (x_cfg_q),
    .y_cfg_i    (y_cfg_q),
    .out_valid_o(front_valid),
    .out_ready_i(!mid_full),
    .out_item_o (front_item)
  );

  // Decoupling queue between front and back
  tcrd_fifo #(
    .Width(CalW),
    .Depth(MidDepth)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_valid),
    .full_o (mid_full),
    .wdata_i(front_item),
    .pop_i  (back_ready),
    .empty_o(mid_empty),
    .rdata_o(mid_item)
  );

  tcrd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (!mid_empty),
    .in_ready_o (back_ready),
    .in_item_i  (mid_item),
    .dwell_cfg_i(dwell_cfg_q),
    .out_valid_o(back_valid),
    .out_ready_i(!out_full),
    .out_item_o (back_item)
  );

  // Result queue facing the consumer
  tcrd_fifo #(
    .Width(ResW),
    .Depth(OutDepth)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (back_valid),
    .full_o (out_full),
    .wdata_i(back_item),
    .pop_i  (pop),
    .empty_o(empty),
    .rdata_o(out_item)
  );

  assign touched_o      = out_item.cal.touched;
  assign cal_x_o        = out_item.cal.cal_x;
  assign cal_y_o        = out_item.cal.cal_y;
  assign dwell_status_o = out_item.status;

endmodule
